### rtl/kest_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kest_pkg
// Shared types, codes and status update functions of the key edge state tracker.
// ----------------------------------------------------------------------------
package kest_pkg;

	// Two-bit status kept for each key
	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_JUST_DOWN = 2'd1,
		ST_HELD      = 2'd2,
		ST_JUST_UP   = 2'd3
	} key_status_t;

	// Item kinds
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Event actions (repeat and the unused code are both ignored)
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;

	// Status after one key event applied to an entry
	function automatic key_status_t next_event_status(
		input key_status_t cur,
		input logic [1:0]  action,
		input logic        capture
	);
		key_status_t nxt;
		nxt = cur;
		if (action == ACT_RELEASE) begin
			if (cur != ST_IDLE) begin
				nxt = ST_JUST_UP;
			end
		end else if (action == ACT_PRESS && !capture) begin
			nxt = ST_JUST_DOWN;
		end
		return nxt;
	endfunction

	// Status after a frame tick passes over an entry
	function automatic key_status_t next_tick_status(input key_status_t cur);
		key_status_t nxt;
		nxt = cur;
		if (cur == ST_JUST_DOWN) begin
			nxt = ST_HELD;
		end else if (cur == ST_JUST_UP) begin
			nxt = ST_IDLE;
		end
		return nxt;
	endfunction

endpackage

### rtl/key_edge_state_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_edge_state_tracker_top
// Per-key status table (not pressed, just pressed, held, just released) in one
// synchronous memory, updated by key events and swept by frame ticks.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, item_kind, key_code,       | sink
//          | key_action, ui_capture                         |
//  out     | out_valid, out_ready, key_state, is_down       | source
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | sink
//
//  From accept to result beat, a right modifier event with merging on runs
//  S_LEFT_RD, S_LEFT_WR, S_KEY_RD, S_KEY_WR (read/write of the left modifier
//  entry, then of the key entry), any other key event S_KEY_RD, S_KEY_WR, and
//  a frame tick S_SWEEP, S_SWEEP_END (one entry per cycle through the memory
//  read port, pipelined against the write port). The result beat in S_DONE
//  and the return to S_IDLE come before the next accept. After reset a clearing
//  pass writes every entry with in_ready low; cfg writes are taken at any time.
//  One item is in flight at a time; a stalled result holds in_ready low.
// ----------------------------------------------------------------------------
module key_edge_state_tracker_top
	import kest_pkg::*;
#(
	parameter int NUM_KEYS        = 512,
	parameter int RIGHT_MOD_FIRST = 344,
	parameter int RIGHT_MOD_LAST  = 347,
	parameter int LEFT_MOD_FIRST  = 340
) (
	input  logic       clk,
	input  logic       arst_n,
	// item input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       item_kind,
	input  logic [8:0] key_code,
	input  logic [1:0] key_action,
	input  logic       ui_capture,
	// result output
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] key_state,
	output logic       is_down,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	localparam int         IW       = $clog2(NUM_KEYS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_KEYS - 1);
	localparam logic [10:0] NK_W    = 11'(NUM_KEYS);
	localparam logic [10:0] RMF_W   = 11'(RIGHT_MOD_FIRST);
	localparam logic [10:0] RML_W   = 11'(RIGHT_MOD_LAST);
	localparam logic [10:0] LMF_W   = 11'(LEFT_MOD_FIRST);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LEFT_RD,
		S_LEFT_WR,
		S_KEY_RD,
		S_KEY_WR,
		S_SWEEP,
		S_SWEEP_END,
		S_DONE
	} fsm_t;

	fsm_t        state_q;
	logic [IW-1:0] sweep_q;
	logic        combine_q;

	// captured item
	logic [8:0]  code_q;
	logic [1:0]  action_q;
	logic        capture_q;
	logic        code_ok_q;
	logic [10:0] left_q;

	// sweep read pipeline
	logic        vld_s1;
	logic [IW-1:0] addr_s1;

	// result register
	logic        out_valid_q;
	key_status_t key_state_q;

	// memory
	logic [1:0]  mem [NUM_KEYS];
	logic [1:0]  rd_s1;
	logic        mem_re;
	logic [IW-1:0] mem_raddr;
	logic        mem_we;
	logic [IW-1:0] mem_waddr;
	key_status_t mem_wdata;

	// decode of the incoming item
	logic [10:0] code_w;
	logic [10:0] left_w;
	logic        code_ok_w;
	logic        left_hit_w;
	logic [IW-1:0] code_idx;
	logic [IW-1:0] left_idx;
	key_status_t ev_next;
	key_status_t tick_next;

	assign code_w     = {2'b00, key_code};
	assign left_w     = code_w - RMF_W + LMF_W;
	assign code_ok_w  = code_w < NK_W;
	assign left_hit_w = combine_q && (code_w >= RMF_W) && (code_w <= RML_W)
		&& (left_w < NK_W);
	assign code_idx   = IW'(code_q);
	assign left_idx   = IW'(left_q);

	assign ev_next   = next_event_status(key_status_t'(rd_s1), action_q, capture_q);
	assign tick_next = next_tick_status(key_status_t'(rd_s1));

	// Drive memory port controls from the sequencer state
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = sweep_q;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = ST_IDLE;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_LEFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = left_idx;
			end
			S_LEFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = left_idx;
				mem_wdata = ev_next;
			end
			S_KEY_RD: begin
				mem_re    = code_ok_q;
				mem_raddr = code_idx;
			end
			S_KEY_WR: begin
				mem_we    = code_ok_q;
				mem_waddr = code_idx;
				mem_wdata = ev_next;
			end
			S_SWEEP: begin
				mem_re    = 1'b1;
				mem_we    = vld_s1;
				mem_waddr = addr_s1;
				mem_wdata = tick_next;
			end
			S_SWEEP_END: begin
				mem_we    = vld_s1;
				mem_waddr = addr_s1;
				mem_wdata = tick_next;
			end
			default: begin
			end
		endcase
	end

	// Status memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_s1 <= mem[mem_raddr];
		end
	end

	// Hold the modifier combining register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combine_q <= 1'b1;
		end else if (cfg_valid) begin
			combine_q <= cfg_data;
		end
	end

	// Sequencer: clear pass, event read-modify-write, frame sweep, result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sweep_q == LAST_IDX) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						code_q      <= key_code;
						action_q    <= key_action;
						capture_q   <= ui_capture;
						code_ok_q   <= code_ok_w;
						left_q      <= left_w;
						key_state_q <= ST_IDLE;
						if (item_kind == KIND_TICK) begin
							state_q <= S_SWEEP;
						end else if (left_hit_w) begin
							state_q <= S_LEFT_RD;
						end else begin
							state_q <= S_KEY_RD;
						end
					end
				end
				S_LEFT_RD: state_q <= S_LEFT_WR;
				S_LEFT_WR: state_q <= S_KEY_RD;
				S_KEY_RD:  state_q <= S_KEY_WR;
				S_KEY_WR: begin
					if (code_ok_q) begin
						key_state_q <= ev_next;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_DONE;
				end
				S_SWEEP: begin
					vld_s1  <= 1'b1;
					addr_s1 <= sweep_q;
					if (vld_s1 && code_ok_q && addr_s1 == code_idx) begin
						key_state_q <= tick_next;
					end
					if (sweep_q == LAST_IDX) begin
						sweep_q <= '0;
						state_q <= S_SWEEP_END;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_SWEEP_END: begin
					vld_s1 <= 1'b0;
					if (vld_s1 && code_ok_q && addr_s1 == code_idx) begin
						key_state_q <= tick_next;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign key_state = key_state_q;
	assign is_down   = (key_state_q == ST_JUST_DOWN) || (key_state_q == ST_HELD);

	// Checks
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result beat is pending");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("memory written outside an item");

	a_sweep_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (sweep_q == '0))
		else $error("sweep index not back at zero");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while busy");

endmodule
